// File: rtl/ssrf_pkg.sv
package ssrf_pkg;

  // receive ring geometry
  localparam int RING_DEPTH = 2048;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  // telemetry double buffer geometry
  localparam int SLOT_BYTES  = 32;
  localparam int SLOT_AW     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int TELEM_DEPTH = 2 * SLOT_BYTES;
  localparam int TELEM_AW    = $clog2(TELEM_DEPTH);

  // request commands
  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_POP   = 2'd1,
    CMD_TELEM = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // controls into the ring
  typedef struct packed {
    logic       push;
    logic [7:0] push_data;
    logic       pop;
  } ring_ctrl_t;

  // status out of the ring
  typedef struct packed {
    logic        empty;
    logic [7:0]  rd_data;
    logic [31:0] dropped_next;
  } ring_stat_t;

endpackage

// File: rtl/ssrf_ring.sv
module ssrf_ring (
  input  logic                  clk,
  input  logic                  rst,
  input  ssrf_pkg::ring_ctrl_t  ctrl,
  output ssrf_pkg::ring_stat_t  stat
);

  logic [7:0]                  mem [ssrf_pkg::RING_DEPTH];
  logic [ssrf_pkg::RING_AW-1:0] wp;
  logic [ssrf_pkg::RING_AW-1:0] rp;
  logic [ssrf_pkg::RING_AW-1:0] wp_inc;
  logic [ssrf_pkg::RING_AW-1:0] rp_inc;
  logic [31:0]                 dropped;
  logic [31:0]                 dropped_next;
  logic [7:0]                  rd_q;
  logic                        full;
  logic                        empty;

  // pointer increments with wrap at the ring depth
  assign wp_inc = (wp == ssrf_pkg::RING_AW'(ssrf_pkg::RING_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_inc = (rp == ssrf_pkg::RING_AW'(ssrf_pkg::RING_DEPTH - 1)) ? '0 : rp + 1'b1;

  // one slot always kept open
  assign full  = (wp_inc == rp);
  assign empty = (wp == rp);

  // a push into a full ring is counted as dropped
  assign dropped_next = dropped + 32'(ctrl.push && full);

  // byte memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (ctrl.push && !full) begin
      mem[wp] <= ctrl.push_data;
    end
    rd_q <= mem[rp];
  end

  // pointers and drop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      dropped <= '0;
    end else begin
      if (ctrl.push && !full) begin
        wp <= wp_inc;
      end
      if (ctrl.pop && !empty) begin
        rp <= rp_inc;
      end
      dropped <= dropped_next;
    end
  end

  assign stat.empty        = empty;
  assign stat.rd_data      = rd_q;
  assign stat.dropped_next = dropped_next;

endmodule

// File: rtl/spi_slave_rx_fifo_telemetry.sv
// SPI slave receive buffer with a telemetry return slot. Each request passes
// through the step and done states before its result is loaded into the
// output register: the two bytes of a received word are written one after
// the other through the single write port of the byte ring, and ring and
// telemetry reads are registered memory reads. A new request is taken in the
// cycle its predecessor's result is loaded into the output register; a held
// result waits for out_ready. Spi events push the high byte then the low byte
// (one slot of the ring stays open, so it holds depth-1 bytes; every byte
// that meets a full ring bumps the wrapping 32-bit overflow count) and, once a
// slot has been published and tx_ready is set, return the next two telemetry
// bytes MSB first. Pop returns the oldest byte, or pop_valid low when empty.
// Telemetry writes fill the inactive half; telem_last flips halves and arms
// transmit. Software writes every slot byte before publishing; the memories
// have no reset and need no clearing pass.
module spi_slave_rx_fifo_telemetry (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic        rx_word_valid,
  input  logic [15:0] rx_word,
  input  logic        tx_ready,
  input  logic [7:0]  telem_byte,
  input  logic [4:0]  telem_index,
  input  logic        telem_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_word_valid,
  output logic [15:0] tx_word,
  output logic        pop_valid,
  output logic [7:0]  pop_byte,
  output logic [31:0] overflow_count
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // latched request
  ssrf_pkg::cmd_t cmd;
  logic           wvalid;
  logic [15:0]    word;
  logic           txr;
  logic [7:0]     tbyte;
  logic [4:0]     tidx;
  logic           tlast;

  logic accept;
  logic done;

  ssrf_pkg::ring_ctrl_t ring_ctrl;
  ssrf_pkg::ring_stat_t ring_stat;

  // telemetry state
  logic [7:0]                    tmem [ssrf_pkg::TELEM_DEPTH];
  logic                          active_half;
  logic [ssrf_pkg::SLOT_AW-1:0]  send_position;
  logic [ssrf_pkg::SLOT_AW-1:0]  p1;
  logic [ssrf_pkg::SLOT_AW:0]    p2_sum;
  logic [ssrf_pkg::SLOT_AW-1:0]  p2;
  logic                          send_armed;
  logic [ssrf_pkg::TELEM_AW-1:0] rd_base;
  logic [ssrf_pkg::TELEM_AW-1:0] wr_base;
  logic [ssrf_pkg::TELEM_AW-1:0] wr_addr;
  logic                          idx_ok;
  logic [7:0]                    tq0;
  logic [7:0]                    tq1;
  logic                          tx_fire;
  logic                          is_event;

  // handshake: a new request enters while the previous result is loaded
  assign done     = (state == ST_DONE) && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) || done;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = accept ? ST_STEP : ST_IDLE;
      ST_STEP: state_next = ST_DONE;
      ST_DONE: state_next = done ? (accept ? ST_STEP : ST_IDLE) : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= ssrf_pkg::cmd_t'(command);
      wvalid <= rx_word_valid;
      word   <= rx_word;
      txr    <= tx_ready;
      tbyte  <= telem_byte;
      tidx   <= telem_index;
      tlast  <= telem_last;
    end
  end

  // ring control: high byte in the step cycle, low byte when the result loads
  assign is_event = (cmd == ssrf_pkg::CMD_EVENT);

  always_comb begin
    ring_ctrl.push      = is_event && wvalid && ((state == ST_STEP) || done);
    ring_ctrl.push_data = (state == ST_STEP) ? word[15:8] : word[7:0];
    ring_ctrl.pop       = done && (cmd == ssrf_pkg::CMD_POP);
  end

  ssrf_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ring_ctrl),
    .stat (ring_stat)
  );

  // send position arithmetic modulo the slot length
  assign p1 = (send_position == ssrf_pkg::SLOT_AW'(ssrf_pkg::SLOT_BYTES - 1)) ?
              '0 : send_position + 1'b1;
  assign p2_sum = {1'b0, send_position} + (ssrf_pkg::SLOT_AW + 1)'(2);
  assign p2 = (p2_sum >= (ssrf_pkg::SLOT_AW + 1)'(ssrf_pkg::SLOT_BYTES)) ?
              ssrf_pkg::SLOT_AW'(p2_sum - (ssrf_pkg::SLOT_AW + 1)'(ssrf_pkg::SLOT_BYTES)) :
              ssrf_pkg::SLOT_AW'(p2_sum);

  // half base addresses
  assign rd_base = active_half ? ssrf_pkg::TELEM_AW'(ssrf_pkg::SLOT_BYTES) : '0;
  assign wr_base = active_half ? '0 : ssrf_pkg::TELEM_AW'(ssrf_pkg::SLOT_BYTES);
  assign wr_addr = wr_base + ssrf_pkg::TELEM_AW'(tidx);
  assign idx_ok  = 32'(tidx) < 32'(ssrf_pkg::SLOT_BYTES);

  // telemetry memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (done && (cmd == ssrf_pkg::CMD_TELEM) && idx_ok) begin
      tmem[wr_addr] <= tbyte;
    end
    tq0 <= tmem[rd_base + ssrf_pkg::TELEM_AW'(send_position)];
    tq1 <= tmem[rd_base + ssrf_pkg::TELEM_AW'(p1)];
  end

  assign tx_fire = is_event && send_armed && txr;

  // telemetry control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_half   <= 1'b0;
      send_position <= '0;
      send_armed    <= 1'b0;
    end else if (done) begin
      if (tx_fire) begin
        send_position <= p2;
      end
      if ((cmd == ssrf_pkg::CMD_TELEM) && tlast) begin
        active_half <= !active_half;
        send_armed  <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      tx_word_valid  <= tx_fire;
      tx_word        <= tx_fire ? {tq0, tq1} : 16'd0;
      pop_valid      <= (cmd == ssrf_pkg::CMD_POP) && !ring_stat.empty;
      pop_byte       <= ((cmd == ssrf_pkg::CMD_POP) && !ring_stat.empty) ?
                        ring_stat.rd_data : 8'd0;
      overflow_count <= ring_stat.dropped_next;
    end
  end

endmodule
